[src/ogru_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogru_pkg
// Shared constants, types and tables of the occupancy grid ray updater.
// ----------------------------------------------------------------------------
package ogru_pkg;

	localparam int GRID_SIZE  = 128;
	localparam int CELL_W     = $clog2(GRID_SIZE);
	localparam int ADDR_W     = 2 * CELL_W;
	localparam int DEPTH      = GRID_SIZE * GRID_SIZE;
	localparam int CORDIC_N   = 14;
	localparam int STEP_W     = $clog2(CORDIC_N + 1);

	localparam logic [7:0]  WALL_CODE = 8'd255;
	localparam logic [20:0] COUNT_MAX = 21'h1FFFFF;
	localparam logic [17:0] CORDIC_GAIN = 18'sd19898;

	// Operation codes
	localparam logic [2:0] OP_POSE  = 3'd0;
	localparam logic [2:0] OP_HIT   = 3'd1;
	localparam logic [2:0] OP_MARK  = 3'd2;
	localparam logic [2:0] OP_DECAY = 3'd3;
	localparam logic [2:0] OP_RDIDX = 3'd4;
	localparam logic [2:0] OP_RDPOS = 3'd5;

	// Register indexes
	localparam logic [1:0] REG_SEEN  = 2'd0;
	localparam logic [1:0] REG_WBASE = 2'd1;
	localparam logic [1:0] REG_WMAX  = 2'd2;
	localparam logic [1:0] REG_MINR  = 2'd3;

	// Datapath commands
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LATCH,     // capture input item
		CMD_RD_POSE,   // read cell under new pose
		CMD_WR_POSE,   // write back pose cell, update counter
		CMD_RD_ITEM,   // read cell of item position/index
		CMD_WR_MARK,
		CMD_CORDIC_INIT,
		CMD_CORDIC_STEP,
		CMD_MUL,       // register products
		CMD_END,       // endpoint cells, Bresenham init
		CMD_RD_END,
		CMD_WR_END,
		CMD_RD_WALK,
		CMD_WR_WALK,   // write walk cell, advance
		CMD_RD_SWEEP,
		CMD_WR_SWEEP   // write decay or clear cell, advance
	} cmd_t;

	typedef struct packed {
		logic ignore;     // range at or below minimum
		logic cordic_done;
		logic walk_done;
		logic sweep_done;
	} status_t;

	function automatic logic signed [17:0] atan_of(input logic [STEP_W-1:0] i);
		case (i)
			4'd0:  atan_of = 18'sd8192;
			4'd1:  atan_of = 18'sd4836;
			4'd2:  atan_of = 18'sd2555;
			4'd3:  atan_of = 18'sd1297;
			4'd4:  atan_of = 18'sd651;
			4'd5:  atan_of = 18'sd326;
			4'd6:  atan_of = 18'sd163;
			4'd7:  atan_of = 18'sd81;
			4'd8:  atan_of = 18'sd41;
			4'd9:  atan_of = 18'sd20;
			4'd10: atan_of = 18'sd10;
			4'd11: atan_of = 18'sd5;
			4'd12: atan_of = 18'sd3;
			4'd13: atan_of = 18'sd1;
			default: atan_of = 18'sd0;
		endcase
	endfunction

	// Cell of a Q8 position, clamped to the grid
	function automatic logic [CELL_W-1:0] cell_of(input logic signed [18:0] p);
		logic signed [10:0] c;
		c = p[18:8];
		if (c < 0)
			cell_of = '0;
		else if (c >= GRID_SIZE)
			cell_of = CELL_W'(GRID_SIZE - 1);
		else
			cell_of = c[CELL_W-1:0];
	endfunction

	// Wall lowering rule shared by walk and decay
	function automatic logic [7:0] lower(input logic [7:0] v, input logic [7:0] wb,
			input logic [7:0] sf);
		logic [7:0] d;
		d = v - 8'd1;
		if (v >= wb)
			lower = (d < wb) ? sf : d;
		else
			lower = v;
	endfunction

endpackage

[src/ogru_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogru_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module ogru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end

endmodule

[src/ogru_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogru_ctrl
// Sequencer: accepts items, steps the datapath, offers results.
// ----------------------------------------------------------------------------
module ogru_ctrl
	import ogru_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic [2:0] op,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t st,
	output cmd_t    cmd,
	output logic    clr_active
);

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_DISP  = 5'd2;
	localparam logic [4:0] S_PRD   = 5'd3;
	localparam logic [4:0] S_PWR   = 5'd4;
	localparam logic [4:0] S_IRD   = 5'd5;
	localparam logic [4:0] S_IWAIT = 5'd6;
	localparam logic [4:0] S_MARK  = 5'd7;
	localparam logic [4:0] S_CINIT = 5'd8;
	localparam logic [4:0] S_CSTEP = 5'd9;
	localparam logic [4:0] S_MUL   = 5'd10;
	localparam logic [4:0] S_END   = 5'd11;
	localparam logic [4:0] S_ERD   = 5'd12;
	localparam logic [4:0] S_EWR   = 5'd13;
	localparam logic [4:0] S_WRD   = 5'd14;
	localparam logic [4:0] S_WWR   = 5'd15;
	localparam logic [4:0] S_SRD   = 5'd16;
	localparam logic [4:0] S_SWR   = 5'd17;
	localparam logic [4:0] S_DONE  = 5'd18;
	localparam logic [4:0] S_PWAIT = 5'd19;

	logic [4:0] state_q;
	logic [2:0] op_q;

	assign in_ready   = (state_q == S_IDLE) && !out_valid;
	assign clr_active = (state_q == S_CLR);

	always_comb begin
		case (state_q)
			S_CLR:   cmd = CMD_WR_SWEEP;
			S_IDLE:  cmd = (in_valid && in_ready) ? CMD_LATCH : CMD_NONE;
			S_PRD:   cmd = CMD_RD_POSE;
			S_PWR:   cmd = CMD_WR_POSE;
			S_IRD:   cmd = CMD_RD_ITEM;
			S_MARK:  cmd = CMD_WR_MARK;
			S_CINIT: cmd = CMD_CORDIC_INIT;
			S_CSTEP: cmd = CMD_CORDIC_STEP;
			S_MUL:   cmd = CMD_MUL;
			S_END:   cmd = CMD_END;
			S_ERD:   cmd = CMD_RD_END;
			S_EWR:   cmd = CMD_WR_END;
			S_WRD:   cmd = CMD_RD_WALK;
			S_WWR:   cmd = CMD_WR_WALK;
			S_SRD:   cmd = CMD_RD_SWEEP;
			S_SWR:   cmd = CMD_WR_SWEEP;
			default: cmd = CMD_NONE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			op_q      <= OP_POSE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				S_CLR:   if (st.sweep_done) state_q <= S_IDLE;
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q    <= op;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					case (op_q)
						OP_POSE:  state_q <= S_PRD;
						OP_HIT:   state_q <= S_CINIT;
						OP_MARK:  state_q <= S_MARK;
						OP_DECAY: state_q <= S_SRD;
						OP_RDIDX: state_q <= S_IRD;
						OP_RDPOS: state_q <= S_IRD;
						default:  state_q <= S_DONE;
					endcase
				end
				S_PRD:   state_q <= S_PWAIT;
				S_PWAIT: state_q <= S_PWR;
				S_PWR:   state_q <= S_DONE;
				S_IRD:   state_q <= S_IWAIT;
				S_IWAIT: state_q <= S_DONE;
				S_MARK:  state_q <= S_DONE;
				S_CINIT: state_q <= st.ignore ? S_DONE : S_CSTEP;
				S_CSTEP: if (st.cordic_done) state_q <= S_MUL;
				S_MUL:   state_q <= S_END;
				S_END:   state_q <= S_ERD;
				S_ERD:   state_q <= S_EWR;
				S_EWR:   state_q <= st.walk_done ? S_DONE : S_WRD;
				// walk stops once the position has reached the endpoint cell
				S_WRD:   state_q <= st.walk_done ? S_DONE : S_WWR;
				S_WWR:   state_q <= S_WRD;
				S_SRD:   state_q <= S_SWR;
				S_SWR:   state_q <= st.sweep_done ? S_DONE : S_SRD;
				S_DONE: begin
					out_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[src/ogru_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogru_dp
// Datapath: pose, CORDIC, Bresenham walker, decay sweep and grid memory.
// ----------------------------------------------------------------------------
module ogru_dp
	import ogru_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic               clr_active,
	input  logic [2:0]         op,
	input  logic signed [16:0] pos_x,
	input  logic signed [16:0] pos_y,
	input  logic [15:0]        heading,
	input  logic [15:0]        distance,
	input  logic [15:0]        sensor_angle,
	input  logic signed [10:0] index_x,
	input  logic signed [10:0] index_y,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output status_t            st,
	output logic [7:0]         cell_value,
	output logic [20:0]        cleaned_count
);

	// Configuration registers
	logic [7:0]  seen_q, wbase_q, wmax_q;
	logic [15:0] minr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 8'd199;
			wbase_q <= 8'd200;
			wmax_q  <= 8'd254;
			minr_q  <= 16'd34;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEEN:  seen_q  <= cfg_data[7:0];
				REG_WBASE: wbase_q <= cfg_data[7:0];
				REG_WMAX:  wmax_q  <= cfg_data[7:0];
				REG_MINR:  minr_q  <= cfg_data;
				default:   ;
			endcase
		end
	end

	// Item capture
	logic [2:0]         op_q;
	logic signed [16:0] px_q, py_q;
	logic [15:0]        hd_in_q, dist_q, sang_q;
	logic signed [10:0] ix_q, iy_q;

	always_ff @(posedge clk) begin
		if (cmd == CMD_LATCH) begin
			op_q    <= op;
			px_q    <= pos_x;
			py_q    <= pos_y;
			hd_in_q <= heading;
			dist_q  <= distance;
			sang_q  <= sensor_angle;
			ix_q    <= index_x;
			iy_q    <= index_y;
		end
	end

	// Pose and counter
	logic signed [16:0] rx_q, ry_q;
	logic [15:0]        rhd_q;
	logic [20:0]        cnt_q;
	logic [7:0]         rdata;
	logic [7:0]         val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q  <= 17'(GRID_SIZE * 128);
			ry_q  <= 17'(GRID_SIZE * 128);
			rhd_q <= '0;
			cnt_q <= '0;
		end else if (cmd == CMD_WR_POSE) begin
			rx_q  <= px_q;
			ry_q  <= py_q;
			rhd_q <= hd_in_q;
			if (rdata < wbase_q && (rdata == 8'd0 || rdata == seen_q) && cnt_q != COUNT_MAX)
				cnt_q <= cnt_q + 21'd1;
		end
	end
	assign cleaned_count = cnt_q;

	// CORDIC, one micro-rotation a cycle
	logic signed [17:0] cx_q, cy_q, cz_q;
	logic               flip_q;
	logic [STEP_W-1:0]  ci_q;
	logic [15:0]        ang;
	logic [15:0]        ang_f;

	assign ang   = rhd_q + sang_q;
	assign ang_f = (ang >= 16'd16384 && ang < 16'd49152) ? ang + 16'd32768 : ang;
	assign st.ignore      = (dist_q <= minr_q);
	assign st.cordic_done = (ci_q == STEP_W'(CORDIC_N - 1));

	always_ff @(posedge clk) begin
		if (cmd == CMD_CORDIC_INIT) begin
			cx_q   <= CORDIC_GAIN;
			cy_q   <= '0;
			cz_q   <= 18'(signed'(ang_f));
			flip_q <= (ang >= 16'd16384 && ang < 16'd49152);
			ci_q   <= '0;
		end else if (cmd == CMD_CORDIC_STEP) begin
			if (!cz_q[17]) begin
				cx_q <= cx_q - (cy_q >>> ci_q);
				cy_q <= cy_q + (cx_q >>> ci_q);
				cz_q <= cz_q - atan_of(ci_q);
			end else begin
				cx_q <= cx_q + (cy_q >>> ci_q);
				cy_q <= cy_q - (cx_q >>> ci_q);
				cz_q <= cz_q + atan_of(ci_q);
			end
			ci_q <= ci_q + STEP_W'(1);
		end
	end

	// Products, then endpoint
	logic signed [35:0] mx_q, my_q;
	logic signed [17:0] sn, cs;
	assign sn = flip_q ? -cy_q : cy_q;
	assign cs = flip_q ? -cx_q : cx_q;

	always_ff @(posedge clk) begin
		if (cmd == CMD_MUL) begin
			mx_q <= signed'({2'b00, dist_q}) * sn + 36'sd16384;
			my_q <= signed'({2'b00, dist_q}) * cs + 36'sd16384;
		end
	end

	logic signed [18:0] ex, ey;
	assign ex = 19'(rx_q) + 19'(mx_q >>> 15);
	assign ey = 19'(ry_q) + 19'(my_q >>> 15);

	// Bresenham walker
	logic [CELL_W-1:0]   x0_q, y0_q, x1_q, y1_q;
	logic signed [CELL_W+1:0] dx_q, dy_q, err_q;
	logic                sx_q, sy_q;
	logic signed [CELL_W+2:0] e2;
	logic [CELL_W-1:0]   ax1, ay1, ax0, ay0;

	assign ax1 = cell_of(ex);
	assign ay1 = cell_of(ey);
	assign ax0 = cell_of(19'(rx_q));
	assign ay0 = cell_of(19'(ry_q));
	assign e2  = {err_q, 1'b0};
	assign st.walk_done = (x0_q == x1_q) && (y0_q == y1_q);

	always_ff @(posedge clk) begin
		if (cmd == CMD_END) begin
			x0_q  <= ax0;
			y0_q  <= ay0;
			x1_q  <= ax1;
			y1_q  <= ay1;
			dx_q  <= (ax1 > ax0) ? (CELL_W+2)'(ax1 - ax0) : (CELL_W+2)'(ax0 - ax1);
			dy_q  <= (ay1 > ay0) ? -(CELL_W+2)'(ay1 - ay0) : -(CELL_W+2)'(ay0 - ay1);
			err_q <= ((ax1 > ax0) ? (CELL_W+2)'(ax1 - ax0) : (CELL_W+2)'(ax0 - ax1))
				- ((ay1 > ay0) ? (CELL_W+2)'(ay1 - ay0) : (CELL_W+2)'(ay0 - ay1));
			sx_q  <= (ax0 < ax1);
			sy_q  <= (ay0 < ay1);
		end else if (cmd == CMD_WR_WALK) begin
			// both updates use the old error
			err_q <= err_q + ((e2 >= dy_q) ? dy_q : '0) + ((e2 <= dx_q) ? dx_q : '0);
			if (e2 >= dy_q) x0_q <= sx_q ? x0_q + 1'b1 : x0_q - 1'b1;
			if (e2 <= dx_q) y0_q <= sy_q ? y0_q + 1'b1 : y0_q - 1'b1;
		end
	end

	// Decay and clear sweep
	logic [ADDR_W-1:0] sw_q;
	assign st.sweep_done = (sw_q == ADDR_W'(DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sw_q <= '0;
		else if (cmd == CMD_WR_SWEEP)
			sw_q <= sw_q + 1'b1;
	end

	// Grid memory port
	logic              we;
	logic [ADDR_W-1:0] addr;
	logic [7:0]        wdata;
	logic              inside_idx;

	assign inside_idx = (ix_q >= 0) && (ix_q < GRID_SIZE) && (iy_q >= 0) && (iy_q < GRID_SIZE);

	always_comb begin
		we    = 1'b0;
		addr  = {cell_of(19'(px_q)), cell_of(19'(py_q))};
		wdata = 8'd0;
		case (cmd)
			CMD_RD_POSE: ;
			CMD_WR_POSE: begin
				we = (rdata < wbase_q) &&
					(rdata == 8'd0 || rdata == seen_q || 9'(rdata) < 9'(wbase_q) - 9'd1);
				wdata = (rdata == 8'd0 || rdata == seen_q) ? 8'd1 : rdata + 8'd1;
			end
			CMD_RD_ITEM:
				if (op_q == OP_RDIDX)
					addr = {ix_q[CELL_W-1:0], iy_q[CELL_W-1:0]};
			CMD_WR_MARK: begin
				we    = 1'b1;
				wdata = WALL_CODE;
			end
			CMD_RD_END, CMD_WR_END: begin
				addr  = {x1_q, y1_q};
				we    = (cmd == CMD_WR_END) && (rdata < wbase_q || rdata < wmax_q);
				wdata = (rdata < wbase_q) ? wbase_q : rdata + 8'd1;
			end
			CMD_RD_WALK, CMD_WR_WALK: begin
				addr  = {x0_q, y0_q};
				we    = (cmd == CMD_WR_WALK);
				wdata = (rdata >= wbase_q) ? lower(rdata, wbase_q, seen_q) :
					(rdata == 8'd0) ? seen_q : rdata;
			end
			CMD_RD_SWEEP, CMD_WR_SWEEP: begin
				addr  = sw_q;
				we    = (cmd == CMD_WR_SWEEP);
				wdata = clr_active ? 8'd0 : lower(rdata, wbase_q, seen_q);
			end
			default: ;
		endcase
	end

	ogru_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	// Read result, captured in the cycle after the read command
	logic rd_pend_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q <= 1'b0;
			val_q     <= '0;
		end else begin
			rd_pend_q <= (cmd == CMD_RD_ITEM);
			if (cmd == CMD_LATCH)
				val_q <= '0;
			else if (rd_pend_q)
				val_q <= (op_q == OP_RDIDX && !inside_idx) ? WALL_CODE : rdata;
		end
	end
	assign cell_value = val_q;

endmodule

[src/occupancy_grid_ray_updater_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_ray_updater_core
// Occupancy grid with pose, ray, mark, decay and read operations.
// ----------------------------------------------------------------------------
// channel | dir | handshake              | payload
// s_axis  | in  | s_axis_tvalid/tready   | op, pos_x, pos_y, heading, dist, angle, ix, iy
// m_axis  | out | m_axis_tvalid/tready   | cell_value, cleaned_count
// cfg     | in  | cfg_we                 | cfg_index, cfg_data
// Ray hits walk the ray cell by cell and decay sweeps every cell of the grid, all through
// the single grid RAM port.
// After reset a clearing pass zeroes the grid; no item is taken.
// One item at a time; the result register holds until taken.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_updater_core
	import ogru_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[2:0], pos_x[19:3], pos_y[36:20], heading[52:37], distance[68:53],
	// sensor_angle[84:69], index_x[95:85], index_y[106:96], zero fill
	input  logic [111:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// cell_value[7:0], cleaned_count[28:8], zero fill
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cmd_t    cmd;
	status_t st;
	logic    clr_active;
	logic [7:0]  cell_value;
	logic [20:0] cleaned_count;

	ogru_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.op         (s_axis_tdata[2:0]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.st         (st),
		.cmd        (cmd),
		.clr_active (clr_active)
	);

	ogru_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.clr_active    (clr_active),
		.op            (s_axis_tdata[2:0]),
		.pos_x         (s_axis_tdata[19:3]),
		.pos_y         (s_axis_tdata[36:20]),
		.heading       (s_axis_tdata[52:37]),
		.distance      (s_axis_tdata[68:53]),
		.sensor_angle  (s_axis_tdata[84:69]),
		.index_x       (s_axis_tdata[95:85]),
		.index_y       (s_axis_tdata[106:96]),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.st            (st),
		.cell_value    (cell_value),
		.cleaned_count (cleaned_count)
	);

	assign m_axis_tdata = {3'b000, cleaned_count, cell_value};

`ifndef SYNTHESIS
	// No item is taken during the clearing pass
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active |-> !s_axis_tready) else $error("item taken while clearing");
	// No item is taken while a result waits
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("item taken with result pending");
	// Counter never falls
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cleaned_count >= $past(cleaned_count)) else $error("counter fell");
`endif

endmodule

[sim/occupancy_grid_ray_updater_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_ray_updater_core_test
// Self-checking bench for the occupancy grid core. A behavioural copy of the
// grid (CORDIC, ray walk, decay, pose cleaning) predicts every result; each
// result transfer is compared with the oldest prediction. Directed items,
// a long output hold-off, register phases and random traffic are run in turn.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_updater_core_test;
	import ogru_pkg::*;

	localparam int RUN_LIMIT = 4000000;

	typedef struct {
		logic [2:0]         op;
		logic signed [16:0] px;
		logic signed [16:0] py;
		logic [15:0]        hd;
		logic [15:0]        reach;
		logic [15:0]        sang;
		logic signed [10:0] ix;
		logic signed [10:0] iy;
	} scan_item_t;

	typedef struct {
		logic [7:0]  cval;
		logic [20:0] count;
	} cell_report_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [111:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [31:0]  m_axis_tdata;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [15:0]  cfg_data;

	// Shadow copy of the block state
	logic [7:0]   map_cells [DEPTH];
	int           robot_x;
	int           robot_y;
	logic [15:0]  robot_hd;
	logic [20:0]  cleaned;
	logic [7:0]   free_code;
	logic [7:0]   wall_lo;
	logic [7:0]   wall_hi;
	logic [15:0]  range_floor;

	cell_report_t pending_reports [$];
	int           fail_count;
	int           cycle_count;
	bit           quiet;        // no idling on either side
	bit           hold_request;
	int           hold_left;
	int           rx_gap;

	occupancy_grid_ray_updater_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("occupancy_grid_ray_updater_core_test: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Shadow model
	// ------------------------------------------------------------------
	function automatic int clamp_cell(input int p);
		int c;
		c = p >>> 8;
		if (c < 0)
			return 0;
		if (c >= GRID_SIZE)
			return GRID_SIZE - 1;
		return c;
	endfunction

	function automatic int cell_addr(input int cx, input int cy);
		return cx * GRID_SIZE + cy;
	endfunction

	function automatic logic [7:0] wall_lowered(input logic [7:0] v);
		logic [7:0] d;
		d = v - 8'd1;
		if (v < wall_lo)
			return v;
		return (d < wall_lo) ? free_code : d;
	endfunction

	task automatic sine_cosine(input logic [15:0] a, output int s, output int c);
		int atan_steps [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
			10, 5, 3, 1};
		int x, y, z, xs, ys;
		logic [15:0] ang;
		bit flip;
		ang = a;
		flip = 0;
		x = 19898;
		y = 0;
		if (ang >= 16'd16384 && ang < 16'd49152) begin
			ang = ang + 16'd32768;
			flip = 1;
		end
		z = (ang >= 16'd32768) ? int'(ang) - 65536 : int'(ang);
		for (int i = 0; i < 14; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_steps[i];
			end else begin
				x += ys; y -= xs; z += atan_steps[i];
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		s = y;
		c = x;
	endtask

	task automatic trace_ray(input logic [15:0] reach, input logic [15:0] sang);
		int s, c, ex, ey, x0, y0, x1, y1, dx, dy, sx, sy, err, e2, a;
		longint prod;
		if (reach <= range_floor)
			return;
		sine_cosine(robot_hd + sang, s, c);
		prod = longint'(reach) * s + 16384;
		ex = robot_x + int'(prod >>> 15);
		prod = longint'(reach) * c + 16384;
		ey = robot_y + int'(prod >>> 15);
		x0 = clamp_cell(robot_x);
		y0 = clamp_cell(robot_y);
		x1 = clamp_cell(ex);
		y1 = clamp_cell(ey);
		// endpoint gains confidence
		a = cell_addr(x1, y1);
		if (map_cells[a] < wall_lo)
			map_cells[a] = wall_lo;
		else if (map_cells[a] < wall_hi)
			map_cells[a] = map_cells[a] + 8'd1;
		// walk up to the endpoint cell
		dx = (x1 > x0) ? x1 - x0 : x0 - x1;
		dy = (y1 > y0) ? y0 - y1 : y1 - y0;
		sx = (x0 < x1) ? 1 : -1;
		sy = (y0 < y1) ? 1 : -1;
		err = dx + dy;
		while (x0 != x1 || y0 != y1) begin
			a = cell_addr(x0, y0);
			if (map_cells[a] >= wall_lo)
				map_cells[a] = wall_lowered(map_cells[a]);
			else if (map_cells[a] == 8'd0)
				map_cells[a] = free_code;
			e2 = 2 * err;
			if (e2 >= dy) begin
				err += dy; x0 += sx;
			end
			if (e2 <= dx) begin
				err += dx; y0 += sy;
			end
		end
	endtask

	// Apply one item to the shadow grid and queue the report it yields
	task automatic grid_apply(input scan_item_t it);
		cell_report_t r;
		int a;
		r.cval = 8'd0;
		case (it.op)
			OP_POSE: begin
				robot_x = int'(it.px);
				robot_y = int'(it.py);
				robot_hd = it.hd;
				a = cell_addr(clamp_cell(robot_x), clamp_cell(robot_y));
				if (map_cells[a] < wall_lo) begin
					if (map_cells[a] == 8'd0 || map_cells[a] == free_code) begin
						if (cleaned != COUNT_MAX)
							cleaned++;
						map_cells[a] = 8'd1;
					end else if (int'(map_cells[a]) < int'(wall_lo) - 1) begin
						map_cells[a] = map_cells[a] + 8'd1;
					end
				end
			end
			OP_HIT:
				trace_ray(it.reach, it.sang);
			OP_MARK:
				map_cells[cell_addr(clamp_cell(int'(it.px)), clamp_cell(int'(it.py)))]
					= WALL_CODE;
			OP_DECAY:
				for (int i = 0; i < DEPTH; i++)
					map_cells[i] = wall_lowered(map_cells[i]);
			OP_RDIDX: begin
				if (it.ix < 0 || it.ix >= GRID_SIZE || it.iy < 0 || it.iy >= GRID_SIZE)
					r.cval = WALL_CODE;
				else
					r.cval = map_cells[cell_addr(int'(it.ix), int'(it.iy))];
			end
			OP_RDPOS:
				r.cval = map_cells[cell_addr(clamp_cell(int'(it.px)),
					clamp_cell(int'(it.py)))];
			default: ;
		endcase
		r.count = cleaned;
		pending_reports.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Result side: random stalls, long hold-off on request, checking
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 7) == 0)
				rx_gap = $urandom_range(1, 14);
		end
	end

	always @(posedge clk) begin
		cell_report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_reports.size() == 0) begin
				$error("result transfer with nothing expected: %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				if (m_axis_tdata[7:0] !== want.cval) begin
					$error("cell_value: expected %0d, got %0d", want.cval,
						m_axis_tdata[7:0]);
					fail_count++;
				end
				if (m_axis_tdata[28:8] !== want.count) begin
					$error("cleaned_count: expected %0d, got %0d", want.count,
						m_axis_tdata[28:8]);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------
	task automatic send_item(input scan_item_t it);
		int gap;
		s_axis_tdata <= {5'd0, it.iy, it.ix, it.sang, it.reach, it.hd, it.py, it.px,
			it.op};
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		grid_apply(it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Lower valid, then wait until the block has answered everything
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		wait (pending_reports.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SEEN:  free_code   = val[7:0];
			REG_WBASE: wall_lo     = val[7:0];
			REG_WMAX:  wall_hi     = val[7:0];
			REG_MINR:  range_floor = val;
			default: ;
		endcase
	endtask

	function automatic scan_item_t make_item(input logic [2:0] op, input int px,
			input int py, input int hd, input int reach, input int sang, input int ix,
			input int iy);
		scan_item_t it;
		it.op = op; it.px = px[16:0]; it.py = py[16:0]; it.hd = hd[15:0];
		it.reach = reach[15:0]; it.sang = sang[15:0]; it.ix = ix[10:0];
		it.iy = iy[10:0];
		return it;
	endfunction

	// Random item, mostly well-formed moves and sensing around the robot
	function automatic scan_item_t random_item;
		scan_item_t it;
		int pick;
		it = make_item(3'($urandom_range(0, 5)), $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom);
		pick = $urandom_range(0, 199);
		if (pick < 2) begin
			it.op = OP_DECAY;
		end else if (pick < 6) begin
			it.op = 3'($urandom_range(6, 7));
		end else if (pick < 12) begin
			it.op = OP_RDIDX;   // anywhere, often outside the grid
		end else if (pick < 190) begin
			it.op = 3'($urandom_range(0, 5));
			if (it.op == OP_DECAY)
				it.op = OP_HIT;
			if (pick < 180) begin
				it.px = 17'($urandom_range(0, GRID_SIZE * 256 - 1));
				it.py = 17'($urandom_range(0, GRID_SIZE * 256 - 1));
				it.reach = 16'($urandom_range(0, 40 * 256));
				it.ix = 11'($urandom_range(0, GRID_SIZE - 1));
				it.iy = 11'($urandom_range(0, GRID_SIZE - 1));
			end
			if (it.op == OP_RDPOS && $urandom_range(0, 1)) begin
				it.px = 17'(robot_x + $urandom_range(0, 4096) - 2048);
				it.py = 17'(robot_y + $urandom_range(0, 4096) - 2048);
			end
		end else begin
			it.op = OP_HIT;   // long rays, full range of fields
		end
		return it;
	endfunction

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			send_item(random_item());
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_reads_after_reset;
		send_item(make_item(OP_RDIDX, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(OP_RDIDX, 0, 0, 0, 0, 0, GRID_SIZE - 1, GRID_SIZE - 1));
		send_item(make_item(OP_RDIDX, 0, 0, 0, 0, 0, -1, 5));
		send_item(make_item(OP_RDIDX, 0, 0, 0, 0, 0, 5, GRID_SIZE));
		send_item(make_item(OP_RDIDX, 0, 0, 0, 0, 0, -1024, 1023));
		send_item(make_item(OP_RDPOS, -65536, 65535, 0, 0, 0, 0, 0));
	endtask

	task automatic test_pose_cleaning;
		send_item(make_item(OP_POSE, 64 * 256, 64 * 256, 0, 0, 0, 0, 0));
		send_item(make_item(OP_POSE, 64 * 256 + 255, 64 * 256, 0, 0, 0, 0, 0));
		send_item(make_item(OP_POSE, 65535, -65536, 65535, 0, 0, 0, 0));
		send_item(make_item(OP_POSE, 10 * 256, 20 * 256, 8192, 0, 0, 0, 0));
	endtask

	task automatic test_hits;
		// ignored at the minimum, then short, long and sideways rays
		send_item(make_item(OP_HIT, 0, 0, 0, 34, 0, 0, 0));
		send_item(make_item(OP_HIT, 0, 0, 0, 35, 0, 0, 0));
		send_item(make_item(OP_HIT, 0, 0, 0, 30 * 256, 16384, 0, 0));
		send_item(make_item(OP_HIT, 0, 0, 0, 65535, 32768, 0, 0));
		send_item(make_item(OP_HIT, 0, 0, 0, 65535, 49152 + 4000, 0, 0));
		send_item(make_item(OP_HIT, 0, 0, 0, 30 * 256, 16384, 0, 0));
		send_item(make_item(OP_RDIDX, 0, 0, 0, 0, 0, 12, 20));
	endtask

	task automatic test_mark_decay;
		send_item(make_item(OP_MARK, 3 * 256, 4 * 256, 0, 0, 0, 0, 0));
		send_item(make_item(OP_DECAY, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(OP_RDIDX, 0, 0, 0, 0, 0, 3, 4));
		send_item(make_item(3'd6, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(3'd7, 0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_output_hold;
		hold_request = 1;
		send_random(30);
	endtask

	task automatic test_register_phases;
		// extremes, including odd orderings of the wall limits
		write_reg(REG_SEEN, 16'd1);
		write_reg(REG_WBASE, 16'd2);
		write_reg(REG_WMAX, 16'd255);
		write_reg(REG_MINR, 16'd0);
		send_random(90);
		write_reg(REG_SEEN, 16'd255);
		write_reg(REG_WBASE, 16'd254);
		write_reg(REG_WMAX, 16'd2);
		write_reg(REG_MINR, 16'd65535);
		send_random(60);
		write_reg(REG_WBASE, 16'hFF00);
		write_reg(REG_MINR, 16'd512);
		send_random(50);
		write_reg(REG_SEEN, 16'd199);
		write_reg(REG_WBASE, 16'd200);
		write_reg(REG_WMAX, 16'd254);
		write_reg(REG_MINR, 16'd34);
	endtask

	task automatic test_random;
		send_random(280);
		quiet = 1;
		send_random(100);
	endtask

	initial begin
		fail_count = 0;
		cycle_count = 0;
		quiet = 0;
		hold_request = 0;
		hold_left = 0;
		rx_gap = 0;
		foreach (map_cells[i])
			map_cells[i] = 8'd0;
		robot_x = GRID_SIZE * 128;
		robot_y = GRID_SIZE * 128;
		robot_hd = 16'd0;
		cleaned = '0;
		free_code = 8'd199;
		wall_lo = 8'd200;
		wall_hi = 8'd254;
		range_floor = 16'd34;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SEEN;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reads_after_reset();
		test_pose_cleaning();
		test_hits();
		test_mark_decay();
		test_output_hold();
		test_register_phases();
		test_random();

		drain();
		if (fail_count == 0)
			$display("occupancy_grid_ray_updater_core_test: clean");
		else
			$display("occupancy_grid_ray_updater_core_test: errors");
		$finish;
	end

endmodule
